[rtl/bmf_pkg.sv]
// ----------------------------------------------------------------------------
// bmf_pkg
// shared constants and controller/datapath types for the box mean filter
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int MAX_KERNEL_DEF = 15;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int KH_W       = 3;
    localparam int DIM_W      = 11;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HALF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [KH_W-1:0]  KH_RESET = 3'd1;
    localparam logic [DIM_W-1:0] IW_RESET = 11'd640;
    localparam logic [DIM_W-1:0] IH_RESET = 11'd480;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic tap_rd;
        logic tap_acc;
        logic store;
        logic sum_rd;
        logic sum_acc;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic taps_done;
        logic sums_done;
        logic div_last;
        logic interior;
        logic out_free;
    } t_status;

endpackage

[rtl/bmf_ctrl.sv]
// ----------------------------------------------------------------------------
// bmf_ctrl
// sequencer stepping one pixel through taps and store, then window sum, divide and output if interior
// ----------------------------------------------------------------------------
module bmf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix_valid,
    input  bmf_pkg::t_status  i_status,
    output logic              o_busy,
    output bmf_pkg::t_cmd     o_cmd
);
    import bmf_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TAP_CHK  = 4'd1;
    localparam logic [3:0] S_TAP_RD   = 4'd2;
    localparam logic [3:0] S_TAP_ACC  = 4'd3;
    localparam logic [3:0] S_STORE    = 4'd4;
    localparam logic [3:0] S_SUM_CHK  = 4'd5;
    localparam logic [3:0] S_SUM_RD   = 4'd6;
    localparam logic [3:0] S_SUM_ACC  = 4'd7;
    localparam logic [3:0] S_DIV_INIT = 4'd8;
    localparam logic [3:0] S_DIV_STEP = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pix_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_TAP_CHK;
                end
            end
            S_TAP_CHK: begin
                n_state = i_status.taps_done ? S_STORE : S_TAP_RD;
            end
            S_TAP_RD: begin
                o_cmd.tap_rd = 1'b1;
                n_state      = S_TAP_ACC;
            end
            S_TAP_ACC: begin
                o_cmd.tap_acc = 1'b1;
                n_state       = S_TAP_CHK;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_status.interior ? S_SUM_CHK : S_IDLE;
            end
            S_SUM_CHK: begin
                n_state = i_status.sums_done ? S_DIV_INIT : S_SUM_RD;
            end
            S_SUM_RD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state       = S_SUM_CHK;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/bmf_datapath.sv]
// ----------------------------------------------------------------------------
// bmf_datapath
// position counters, line store, column sums, window sum and divider
// ----------------------------------------------------------------------------
module bmf_datapath #(
    parameter int MAX_KERNEL = bmf_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [bmf_pkg::PIX_W-1:0]         i_pixel,
    input  logic                              i_frame_start,
    input  bmf_pkg::t_cmd                     i_cmd,
    output bmf_pkg::t_status                  o_status,
    input  logic                              i_res_stall,
    output logic                              o_res_valid,
    output logic [bmf_pkg::PIX_W-1:0]         o_mean_value,
    output logic [bmf_pkg::POS_W-1:0]         o_center_row,
    output logic [bmf_pkg::POS_W-1:0]         o_center_column,
    output logic                              o_frame_done
);
    import bmf_pkg::*;

    localparam int CW_W     = $clog2(MAX_WIDTH + 1);
    localparam int RW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int COL_AW   = $clog2(MAX_WIDTH);
    localparam int SLOT_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
    localparam int HALF_W   = $clog2(HALF_MAX + 2);
    localparam int SPAN_W   = HALF_W + 1;
    localparam int SIDE_W   = SPAN_W + 1;
    localparam int AREA_W   = 2 * SIDE_W;
    localparam int CS_W     = $clog2(MAX_KERNEL * 255 + 1);
    localparam int WS_W     = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int TR_W     = WS_W + PIX_W;
    localparam int LS_AW    = SLOT_W + COL_AW;

    // configuration
    logic [KH_W-1:0]  r_kernel_half;
    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_half  <= KH_RESET;
            r_image_width  <= IW_RESET;
            r_image_height <= IH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KERNEL_HALF:  r_kernel_half  <= i_cfg_data[KH_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CW_W-1:0]   w_eff;
    logic [RW_W-1:0]   h_eff;
    logic [HALF_W-1:0] half;
    logic [SPAN_W-1:0] span;
    logic [SIDE_W-1:0] side;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CW_W'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_eff = CW_W'(MAX_WIDTH);
        end else begin
            w_eff = CW_W'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = RW_W'(1);
        end else if (int'(r_image_height) > MAX_HEIGHT) begin
            h_eff = RW_W'(MAX_HEIGHT);
        end else begin
            h_eff = RW_W'(r_image_height);
        end
        if (int'(r_kernel_half) > HALF_MAX) begin
            half = HALF_W'(HALF_MAX);
        end else begin
            half = HALF_W'(r_kernel_half);
        end
        span = {half, 1'b0};
        side = SIDE_W'(span) + SIDE_W'(1);
    end

    // position of the next pixel
    logic [CW_W-1:0]   r_col_cnt;
    logic [RW_W-1:0]   r_row_cnt;
    logic [SLOT_W-1:0] r_slot_cnt;

    // current pixel
    logic [PIX_W-1:0]  r_pix;
    logic [CW_W-1:0]   r_col;
    logic [RW_W-1:0]   r_row;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_tap_slot;
    logic [SPAN_W-1:0] r_taps;
    logic [CS_W-1:0]   r_cs;
    logic [COL_AW-1:0] r_sum_c;
    logic [SIDE_W-1:0] r_sums;
    logic [WS_W-1:0]   r_ws;
    logic [WS_W-1:0]   r_rem;
    logic [AREA_W-1:0] r_area;
    logic [PIX_W-1:0]  r_q;
    logic [2:0]        r_k;

    // memory read data
    logic [PIX_W-1:0]  ls_rdata;
    logic [CS_W-1:0]   cs_rdata;

    // position of the arriving pixel after frame start and wraps
    logic [CW_W-1:0]   c0;
    logic [RW_W-1:0]   r0;
    logic [SLOT_W-1:0] s0;

    always_comb begin
        c0 = i_frame_start ? '0 : r_col_cnt;
        r0 = i_frame_start ? '0 : r_row_cnt;
        s0 = i_frame_start ? '0 : r_slot_cnt;
        if (c0 >= w_eff) begin
            c0 = '0;
            r0 = r0 + RW_W'(1);
            s0 = (s0 == SLOT_W'(MAX_KERNEL - 1)) ? '0 : s0 + SLOT_W'(1);
        end
        if (r0 >= h_eff) begin
            r0 = '0;
            s0 = '0;
        end
    end

    logic [SLOT_W-1:0] tap_prev;
    logic [CW_W-1:0]   col_nx;
    logic [RW_W-1:0]   row_nx;
    logic [SLOT_W-1:0] slot_nx;
    logic              interior;

    assign tap_prev = (r_tap_slot == '0) ? SLOT_W'(MAX_KERNEL - 1) : r_tap_slot - SLOT_W'(1);
    assign col_nx   = r_col + CW_W'(1);
    assign row_nx   = r_row + RW_W'(1);
    assign slot_nx  = (r_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : r_slot + SLOT_W'(1);
    assign interior = (int'(r_row) >= int'(span)) && (int'(r_col) >= int'(span));

    // divider trial value: area shifted to the current quotient bit
    logic [TR_W-1:0] trial;
    assign trial = TR_W'(r_area) << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_slot_cnt <= '0;
            r_ws       <= '0;
        end else begin
            if (i_cmd.store) begin
                if (col_nx >= w_eff) begin
                    r_col_cnt <= '0;
                    if (row_nx >= h_eff) begin
                        r_row_cnt  <= '0;
                        r_slot_cnt <= '0;
                    end else begin
                        r_row_cnt  <= row_nx;
                        r_slot_cnt <= slot_nx;
                    end
                end else begin
                    r_col_cnt  <= col_nx;
                    r_row_cnt  <= r_row;
                    r_slot_cnt <= r_slot;
                end
                r_ws <= '0;
            end
            if (i_cmd.sum_acc) begin
                r_ws <= r_ws + WS_W'(cs_rdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix      <= i_pixel;
            r_col      <= c0;
            r_row      <= r0;
            r_slot     <= s0;
            r_tap_slot <= s0;
            r_taps     <= span;
            r_cs       <= CS_W'(i_pixel);
        end
        if (i_cmd.tap_rd) begin
            r_tap_slot <= tap_prev;
            r_taps     <= r_taps - SPAN_W'(1);
        end
        if (i_cmd.tap_acc) begin
            r_cs <= r_cs + CS_W'(ls_rdata);
        end
        if (i_cmd.store) begin
            r_sum_c <= r_col[COL_AW-1:0] - COL_AW'(span);
            r_sums  <= side;
        end
        if (i_cmd.sum_rd) begin
            r_sum_c <= r_sum_c + COL_AW'(1);
            r_sums  <= r_sums - SIDE_W'(1);
        end
        if (i_cmd.div_init) begin
            r_rem  <= r_ws;
            r_area <= AREA_W'(side) * AREA_W'(side);
            r_q    <= '0;
            r_k    <= 3'd7;
        end
        if (i_cmd.div_step) begin
            if (TR_W'(r_rem) >= trial) begin
                r_rem    <= r_rem - WS_W'(trial);
                r_q[r_k] <= 1'b1;
            end
            r_k <= r_k - 3'd1;
        end
    end

    // line store: previous rows, one row per slot
    logic [PIX_W-1:0] line_mem [0:(1 << LS_AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            line_mem[{r_slot, r_col[COL_AW-1:0]}] <= r_pix;
        end
        if (i_cmd.tap_rd) begin
            ls_rdata <= line_mem[{tap_prev, r_col[COL_AW-1:0]}];
        end
    end

    // column sums, one per column
    logic [CS_W-1:0] colsum_mem [0:(1 << COL_AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            colsum_mem[r_col[COL_AW-1:0]] <= r_cs;
        end
        if (i_cmd.sum_rd) begin
            cs_rdata <= colsum_mem[r_sum_c];
        end
    end

    // output register
    logic r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mean_value    <= r_q;
            o_center_row    <= POS_W'(r_row - RW_W'(half));
            o_center_column <= POS_W'(r_col - CW_W'(half));
            o_frame_done    <= (r_row == h_eff - RW_W'(1)) && (r_col == w_eff - CW_W'(1));
        end
    end

    assign o_res_valid = r_res_valid;

    assign o_status.taps_done = (r_taps == '0);
    assign o_status.sums_done = (r_sums == '0);
    assign o_status.div_last  = (r_k == 3'd0);
    assign o_status.interior  = interior;
    assign o_status.out_free  = !r_res_valid || !i_res_stall;

endmodule

[rtl/box_mean_filter_2d.sv]
// ----------------------------------------------------------------------------
// box_mean_filter_2d
// mean of the odd square window around each interior pixel of a raster stream
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  pixel     in         i_pix_valid / o_pix_stall    i_pixel, i_frame_start
//  result    out        o_res_valid / i_res_stall    o_mean_value, o_center_row,
//                                                    o_center_column, o_frame_done
//  config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  a pixel reads span taps from the line store and is stored; when it closes a
//  window it then reads side column sums, divides and waits out any result stall
//  before the load (span = 2*kernel_half, side = span+1); the line store and
//  column-sum memory are read one entry at a time, the divide is 8 steps
//  synchronous active-low reset clears counters, control and result valid
//  the result register holds under stall; a new pixel is taken while it waits
//
module box_mean_filter_2d #(
    parameter int MAX_KERNEL = bmf_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel transfer
    input  logic                           i_pix_valid,
    output logic                           o_pix_stall,
    input  logic [bmf_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_frame_start,
    // result transfer
    output logic                           o_res_valid,
    input  logic                           i_res_stall,
    output logic [bmf_pkg::PIX_W-1:0]      o_mean_value,
    output logic [bmf_pkg::POS_W-1:0]      o_center_row,
    output logic [bmf_pkg::POS_W-1:0]      o_center_column,
    output logic                           o_frame_done
);
    import bmf_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;

    // sequencer: one pixel in flight at a time
    bmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .i_status    (status),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    // stores, running sums, divider and result register
    bmf_datapath #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pixel),
        .i_frame_start   (i_frame_start),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_res_stall     (i_res_stall),
        .o_res_valid     (o_res_valid),
        .o_mean_value    (o_mean_value),
        .o_center_row    (o_center_row),
        .o_center_column (o_center_column),
        .o_frame_done    (o_frame_done)
    );

    // pixel side is held off while a pixel is being worked on
    assign o_pix_stall = busy;

    // an accepted pixel keeps the input stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !o_pix_stall) |=> o_pix_stall)
        else $error("pixel side not stalled after a transfer");

    // a new result only appears from the output load command
    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(cmd.load_out))
        else $error("result valid without a load");

    // divider only runs while a pixel is in flight
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_init || cmd.div_step) |-> o_pix_stall)
        else $error("divider active while idle");

endmodule
